// ===== rtl/core/nearest_palette_index_unit_assert.svh =====
// assertion macros for the nearest palette index unit
`ifndef NEAREST_PALETTE_INDEX_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_INDEX_UNIT_ASSERT_SVH

// same-cycle implication
`define NPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define NPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/npi_pkg.sv =====
// shared constants and opcodes of the nearest palette index unit
`default_nettype none
package npi_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COMPONENT_BITS_DEF  = 5;

    localparam int IDX_W        = 8;
    localparam int PORT_COMP_W  = 5;
    localparam int COMP_MAX_W   = 8;
    localparam int DIST_OUT_W   = 12;

    localparam logic [DIST_OUT_W-1:0] DIST_SAT = 12'hFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/nearest_palette_index_unit.sv =====
// top level: palette store, scan sequencer and running minimum of the nearest palette search
// A write transaction (opcode 0) stores one palette entry at the accepting edge and
// leaves busy low, so another transaction can follow in the next cycle; indexes at or
// above PALETTE_ENTRIES are dropped. A map transaction (opcode 1) raises busy: the
// sequencer reads entries 1 to PALETTE_ENTRIES-1 from the single read port of the
// palette memory, one per cycle, through a two-stage distance unit and a running-minimum
// compare, and the three-stage pipeline is drained before busy drops. The result
// appears on o_valid for exactly one cycle, in the same cycle that busy drops; the
// receiver cannot stall it and must capture it then. Ties go to the lowest index. The
// palette reads as all zero right after reset, with no clearing time.
`default_nettype none
module nearest_palette_index_unit #(
    parameter int PALETTE_ENTRIES = npi_pkg::PALETTE_ENTRIES_DEF,
    parameter int COMPONENT_BITS  = npi_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_opcode,
    input  wire logic [npi_pkg::IDX_W-1:0]       i_entry_index,
    input  wire logic [npi_pkg::PORT_COMP_W-1:0] i_red,
    input  wire logic [npi_pkg::PORT_COMP_W-1:0] i_green,
    input  wire logic [npi_pkg::PORT_COMP_W-1:0] i_blue,
    input  wire logic                            i_last_pixel,
    output logic                                 o_valid,
    output logic [npi_pkg::IDX_W-1:0]            o_palette_index,
    output logic [npi_pkg::DIST_OUT_W-1:0]       o_distance,
    output logic                                 o_end_of_image
);
    import npi_pkg::*;

    localparam int AW     = $clog2(PALETTE_ENTRIES);
    localparam int CW     = COMPONENT_BITS;
    localparam int DW     = 3 * CW;
    localparam int DIST_W = 2 * CW + 2;
    localparam int SAT_W  = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;
    localparam int LAT    = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    t_state r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_pix_r, r_pix_g, r_pix_b;
    logic [CW-1:0]     n_pix_r, n_pix_g, n_pix_b;
    logic              r_eoi, n_eoi;
    logic [DIST_W-1:0] r_best_dist, n_best_dist;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic              r_valid, n_valid;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [DIST_OUT_W-1:0] r_out_dist, n_out_dist;
    logic              r_out_eoi, n_out_eoi;

    t_tag r_tag [LAT];
    t_tag n_tag0;

    logic [COMP_MAX_W-1:0] red_ext, green_ext, blue_ext;
    logic [CW-1:0]     in_r, in_g, in_b;
    logic              accept;
    logic              wr_en;
    logic [DW-1:0]     rd_data;
    logic [DIST_W-1:0] ent_dist;
    logic [SAT_W-1:0]  best_ext;
    logic              take;

    // mask components to the configured width
    assign red_ext   = COMP_MAX_W'(i_red);
    assign green_ext = COMP_MAX_W'(i_green);
    assign blue_ext  = COMP_MAX_W'(i_blue);
    assign in_r      = red_ext[CW-1:0];
    assign in_g      = green_ext[CW-1:0];
    assign in_b      = blue_ext[CW-1:0];

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_opcode == OP_WRITE) &&
                    ({1'b0, i_entry_index} < (IDX_W+1)'(PALETTE_ENTRIES));

    npi_palette_mem #(
        .ENTRIES (PALETTE_ENTRIES),
        .DATA_W  (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_entry_index[AW-1:0]),
        .i_wr_data ({in_r, in_g, in_b}),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    npi_dist_unit #(
        .COMP_W (CW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_pix_r (r_pix_r),
        .i_pix_g (r_pix_g),
        .i_pix_b (r_pix_b),
        .i_ent_r (rd_data[DW-1:2*CW]),
        .i_ent_g (rd_data[2*CW-1:CW]),
        .i_ent_b (rd_data[CW-1:0]),
        .o_dist  (ent_dist)
    );

    always_comb begin
        n_tag0.valid = (r_state == ST_ISSUE);
        n_tag0.first = (r_addr == AW'(1));
        n_tag0.last  = (r_addr == AW'(PALETTE_ENTRIES - 1));
        n_tag0.idx   = IDX_W'(r_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= n_tag0;
            for (int k = 1; k < LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // strict compare keeps the lowest index on a tie
    assign take = r_tag[LAT-1].first || (ent_dist < r_best_dist);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pix_r     = r_pix_r;
        n_pix_g     = r_pix_g;
        n_pix_b     = r_pix_b;
        n_eoi       = r_eoi;
        n_best_dist = r_best_dist;
        n_best_idx  = r_best_idx;
        n_valid     = 1'b0;
        n_out_idx   = r_out_idx;
        n_out_dist  = r_out_dist;
        n_out_eoi   = r_out_eoi;

        if (r_tag[LAT-1].valid && take) begin
            n_best_dist = ent_dist;
            n_best_idx  = r_tag[LAT-1].idx;
        end
        best_ext = SAT_W'(n_best_dist);

        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_opcode == OP_MAP)) begin
                    n_state = ST_ISSUE;
                    n_addr  = AW'(1);
                    n_pix_r = in_r;
                    n_pix_g = in_g;
                    n_pix_b = in_b;
                    n_eoi   = i_last_pixel;
                end
            end
            ST_ISSUE: begin
                if (r_addr == AW'(PALETTE_ENTRIES - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_tag[LAT-1].valid && r_tag[LAT-1].last) begin
                    n_state    = ST_IDLE;
                    n_valid    = 1'b1;
                    n_out_idx  = n_best_idx;
                    n_out_dist = (best_ext > SAT_W'(DIST_SAT)) ? DIST_SAT
                                                              : best_ext[DIST_OUT_W-1:0];
                    n_out_eoi  = r_eoi;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pix_r     <= n_pix_r;
            r_pix_g     <= n_pix_g;
            r_pix_b     <= n_pix_b;
            r_eoi       <= n_eoi;
            r_best_dist <= n_best_dist;
            r_best_idx  <= n_best_idx;
            r_valid     <= n_valid;
            r_out_idx   <= n_out_idx;
            r_out_dist  <= n_out_dist;
            r_out_eoi   <= n_out_eoi;
        end
    end

    assign o_valid         = r_valid;
    assign o_palette_index = r_out_idx;
    assign o_distance      = r_out_dist;
    assign o_end_of_image  = r_out_eoi;

endmodule
`default_nettype wire

// ===== rtl/core/npi_palette_mem.sv =====
// palette memory with one write port, one registered read port and reset valid bits
`default_nettype none
module npi_palette_mem #(
    parameter int ENTRIES = npi_pkg::PALETTE_ENTRIES_DEF,
    parameter int DATA_W  = 3 * npi_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]          i_wr_data,
    input  wire logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]          o_rd_data
);
    logic [DATA_W-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_entry_valid;
    logic [DATA_W-1:0] r_rd_mem;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_mem <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_entry_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_entry_valid[i_rd_addr];
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_rd_valid ? r_rd_mem : '0;

endmodule
`default_nettype wire

// ===== rtl/core/npi_dist_unit.sv =====
// two-stage squared rgb distance unit, one entry per cycle
`default_nettype none
module npi_dist_unit #(
    parameter int COMP_W = npi_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic [COMP_W-1:0]     i_pix_r,
    input  wire logic [COMP_W-1:0]     i_pix_g,
    input  wire logic [COMP_W-1:0]     i_pix_b,
    input  wire logic [COMP_W-1:0]     i_ent_r,
    input  wire logic [COMP_W-1:0]     i_ent_g,
    input  wire logic [COMP_W-1:0]     i_ent_b,
    output logic      [2*COMP_W+1:0]   o_dist
);
    localparam int SQ_W   = 2 * COMP_W;
    localparam int DIST_W = 2 * COMP_W + 2;

    logic [COMP_W-1:0] diff_r;
    logic [COMP_W-1:0] diff_g;
    logic [COMP_W-1:0] diff_b;
    logic [SQ_W-1:0]   r_sq_r;
    logic [SQ_W-1:0]   r_sq_g;
    logic [SQ_W-1:0]   r_sq_b;
    logic [DIST_W-1:0] r_sum;

    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    always_comb begin
        diff_r = abs_diff(i_pix_r, i_ent_r);
        diff_g = abs_diff(i_pix_g, i_ent_g);
        diff_b = abs_diff(i_pix_b, i_ent_b);
    end

    always_ff @(posedge i_clk) begin
        r_sq_r <= SQ_W'(diff_r) * SQ_W'(diff_r);
        r_sq_g <= SQ_W'(diff_g) * SQ_W'(diff_g);
        r_sq_b <= SQ_W'(diff_b) * SQ_W'(diff_b);
        r_sum  <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    assign o_dist = r_sum;

endmodule
`default_nettype wire

// ===== rtl/core/npi_port_checker.sv =====
// port-level checks of the nearest palette index unit and their bind
`default_nettype none
module npi_port_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            i_opcode,
    input  wire logic                            o_valid,
    input  wire logic [npi_pkg::IDX_W-1:0]       o_palette_index
);
    import npi_pkg::*;

`include "nearest_palette_index_unit_assert.svh"

    logic map_txn;
    logic write_txn;

    assign map_txn   = start && !busy && (i_opcode == OP_MAP);
    assign write_txn = start && !busy && (i_opcode == OP_WRITE);

    `NPI_ASSERT_NXT(a_map_sets_busy, i_clk, i_rst_n, map_txn, busy)
    `NPI_ASSERT_NXT(a_write_no_busy, i_clk, i_rst_n, write_txn, !busy)
    `NPI_ASSERT_IMP(a_result_ends_search, i_clk, i_rst_n, o_valid, !busy && $past(busy))
    `NPI_ASSERT_IMP(a_no_background, i_clk, i_rst_n, o_valid, o_palette_index != '0)
    `NPI_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

bind nearest_palette_index_unit npi_port_checker u_npi_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_opcode        (i_opcode),
    .o_valid         (o_valid),
    .o_palette_index (o_palette_index)
);
`default_nettype wire
